FILE: rtl/core/touch_slot_decoder_with_calibration_core_assert.svh
// Assertion macros shared by the checker files of the touch slot decoder.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef TOUCH_SLOT_DECODER_WITH_CALIBRATION_CORE_ASSERT_SVH
`define TOUCH_SLOT_DECODER_WITH_CALIBRATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSDC_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tsdc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSDC_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tsdc: next-cycle check failed");

`endif

FILE: rtl/core/tsdc_pkg.sv
// Shared types, codes and constants of the touch slot decoder.
// No dependencies; imported by every module of the block.
package tsdc_pkg;

    localparam int SLOTS_PER_FRAME_DEF = 8;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_X_LOWER = 3'd0,
        CFG_X_UPPER = 3'd1,
        CFG_Y_LOWER = 3'd2,
        CFG_Y_UPPER = 3'd3,
        CFG_X_GAIN  = 3'd4,
        CFG_Y_GAIN  = 3'd5,
        CFG_X_SHIFT = 3'd6,
        CFG_Y_SHIFT = 3'd7
    } cfg_index_t;

    // Report kinds.
    localparam logic [1:0] KIND_DOWN    = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_SYNC    = 2'd2;

    localparam logic [1:0] STATUS_DOWN = 2'd2;

    // Ids below this limit are tracked in the down masks.
    localparam int MASK_IDS = 8;

    // floor(n / 1000) == (n * DIV_RECIP) >> RECIP_SHIFT for n < 2**27.
    localparam logic [30:0] DIV_RECIP   = 31'd1099511628;
    localparam int          RECIP_SHIFT = 40;

    typedef struct packed {
        logic [11:0]        x_lower;
        logic [11:0]        x_upper;
        logic [11:0]        y_lower;
        logic [11:0]        y_upper;
        logic signed [15:0] x_gain;
        logic signed [15:0] y_gain;
        logic signed [12:0] x_shift;
        logic signed [12:0] y_shift;
    } cfg_t;

    // One classified slot record, as the front end hands it to the back end.
    typedef struct packed {
        logic        down;
        logic [4:0]  id;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [7:0]  area;
        logic [7:0]  pressure;
        logic        frame_end;
        logic [7:0]  release_mask;
    } cmd_t;

endpackage

FILE: rtl/core/tsdc_queue.sv
// Short command queue between the front end and the back end.
// Depends on tsdc_pkg for the command type.
module tsdc_queue
    import tsdc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/core/tsdc_front.sv
// Front end: accepts slot records, tracks frame position and down masks,
// and queues a command for each record that causes reports. Uses tsdc_pkg.
module tsdc_front
    import tsdc_pkg::*;
#(
    parameter int SLOTS_PER_FRAME = SLOTS_PER_FRAME_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] id_status,
    input  logic [7:0] x_high,
    input  logic [7:0] y_high,
    input  logic [7:0] xy_low,
    input  logic [7:0] contact_area,
    input  logic [7:0] contact_pressure,
    input  logic       queue_full,
    output logic       push,
    output cmd_t       cmd
);

    localparam int SW = (SLOTS_PER_FRAME > 1) ? $clog2(SLOTS_PER_FRAME) : 1;

    logic [SW-1:0] slot_pos_reg;
    logic [7:0]    cur_mask_reg;
    logic [7:0]    prev_mask_reg;

    logic       accept;
    logic       is_down;
    logic       frame_end;
    logic [4:0] id;
    logic [7:0] id_bit;
    logic [7:0] cur_next;

    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;
    assign id        = id_status[7:3];
    assign is_down   = (id_status[1:0] == STATUS_DOWN);
    assign frame_end = (slot_pos_reg == SW'(SLOTS_PER_FRAME - 1));
    assign id_bit    = (is_down && (id < 5'(MASK_IDS))) ? (8'd1 << id[2:0]) : 8'd0;
    assign cur_next  = cur_mask_reg | id_bit;

    // Drop records that cause nothing; everything else goes to the back end.
    assign push = accept && (is_down || frame_end);

    always_comb
    begin
        cmd.down      = is_down;
        cmd.id        = id;
        cmd.raw_x     = {x_high, xy_low[7:4]};
        cmd.raw_y     = {y_high, xy_low[3:0]};
        cmd.area      = contact_area;
        cmd.pressure  = contact_pressure;
        cmd.frame_end = frame_end;
        // Id 0 is tracked but never released.
        cmd.release_mask = frame_end ? (prev_mask_reg & ~cur_next & 8'hfe) : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_pos_reg  <= '0;
            cur_mask_reg  <= '0;
            prev_mask_reg <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                slot_pos_reg  <= '0;
                cur_mask_reg  <= '0;
                prev_mask_reg <= cur_next;
            end
            else
            begin
                slot_pos_reg <= slot_pos_reg + 1'b1;
                cur_mask_reg <= cur_next;
            end
        end
    end

endmodule

FILE: rtl/core/tsdc_back.sv
// Back end: calibration pipeline, report sequencer and output register.
// Uses tsdc_pkg for the command, configuration and report codes.
module tsdc_back
    import tsdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  report_kind,
    output logic [4:0]  slot_id,
    output logic [11:0] pos_x,
    output logic [11:0] pos_y,
    output logic [7:0]  touch_major,
    output logic [7:0]  width_major,
    output logic        last_of_run
);

    // Final step of one axis: apply the signed quotient and offset, clamp.
    function automatic logic [11:0] finish_axis(
        input logic [11:0]        v,
        input logic [17:0]        q,
        input logic               neg,
        input logic signed [12:0] shift,
        input logic [11:0]        lo,
        input logic [11:0]        hi
    );
        logic signed [20:0] corr;
        logic signed [20:0] r;
        logic signed [20:0] lo_s;
        logic signed [20:0] hi_s;
        corr = neg ? -$signed({3'b000, q}) : $signed({3'b000, q});
        lo_s = $signed({9'b0, lo});
        hi_s = $signed({9'b0, hi});
        r    = $signed({9'b0, v}) + corr + $signed({{8{shift[12]}}, shift});
        if (r < lo_s)
        begin
            r = lo_s;
        end
        if (r > hi_s)
        begin
            r = hi_s;
        end
        return r[11:0];
    endfunction

    // Magnitude of the gain product divided by 1000.
    function automatic logic [17:0] div_mag(input logic signed [28:0] p);
        logic signed [28:0] pabs;
        logic [57:0]        prod;
        pabs = p[28] ? -p : p;
        prod = 58'(pabs[26:0]) * 58'(DIV_RECIP);
        return prod[RECIP_SHIFT+17:RECIP_SHIFT];
    endfunction

    // Stage 1: gain products.
    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic signed [28:0] s1_px_reg;
    logic signed [28:0] s1_py_reg;

    logic signed [12:0] dx;
    logic signed [12:0] dy;
    logic signed [28:0] px_next;
    logic signed [28:0] py_next;

    // Stage 2: report sequencer holding one command.
    logic        e_valid_reg;
    logic        e_down_reg;
    logic        e_sync_reg;
    logic [7:0]  e_rel_reg;
    logic [4:0]  e_id_reg;
    logic [7:0]  e_area_reg;
    logic [7:0]  e_press_reg;
    logic [11:0] e_vx_reg;
    logic [11:0] e_vy_reg;
    logic [17:0] e_qx_reg;
    logic [17:0] e_qy_reg;
    logic        e_nx_reg;
    logic        e_ny_reg;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [4:0]  id_reg;
    logic [11:0] pos_x_reg;
    logic [11:0] pos_y_reg;
    logic [7:0]  major_reg;
    logic [7:0]  width_reg;
    logic        last_reg;

    logic       out_free;
    logic       emit;
    logic       e_done;
    logic       e_ready;
    logic       s1_ready;
    logic       s1_adv;
    logic [7:0] rel_bit;
    logic [7:0] rel_left;
    logic [4:0] rel_id;
    logic [1:0] kind_sel;
    logic       last_sel;

    assign dx = $signed({1'b0, q_cmd.raw_x}) - $signed({2'b00, cfg.x_upper[11:1]});
    assign dy = $signed({1'b0, q_cmd.raw_y}) - $signed({2'b00, cfg.y_upper[11:1]});
    assign px_next = 29'(dx) * 29'(cfg.x_gain);
    assign py_next = 29'(dy) * 29'(cfg.y_gain);

    assign rel_bit  = e_rel_reg & (~e_rel_reg + 8'd1);
    assign rel_left = e_rel_reg & ~rel_bit;

    always_comb
    begin
        rel_id = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (rel_bit[i])
            begin
                rel_id = 5'(i);
            end
        end
    end

    // Down report first, then releases in ascending id order, then sync.
    always_comb
    begin
        priority if (e_down_reg)
        begin
            kind_sel = KIND_DOWN;
            last_sel = !(|e_rel_reg) && !e_sync_reg;
        end
        else if (|e_rel_reg)
        begin
            kind_sel = KIND_RELEASE;
            last_sel = !(|rel_left) && !e_sync_reg;
        end
        else
        begin
            kind_sel = KIND_SYNC;
            last_sel = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = e_valid_reg && out_free;
    assign e_done   = emit && last_sel;
    assign e_ready  = !e_valid_reg || e_done;
    assign s1_adv   = s1_valid_reg && e_ready;
    assign s1_ready = !s1_valid_reg || e_ready;
    assign q_pop    = q_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            e_valid_reg   <= 1'b0;
            e_down_reg    <= 1'b0;
            e_sync_reg    <= 1'b0;
            e_rel_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                e_valid_reg <= 1'b1;
                e_down_reg  <= s1_cmd_reg.down;
                e_sync_reg  <= s1_cmd_reg.frame_end;
                e_rel_reg   <= s1_cmd_reg.release_mask;
            end
            else if (e_done)
            begin
                e_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                if (e_down_reg)
                begin
                    e_down_reg <= 1'b0;
                end
                else
                begin
                    e_rel_reg <= rel_left;
                end
            end

            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_cmd_reg <= q_cmd;
            s1_px_reg  <= px_next;
            s1_py_reg  <= py_next;
        end
        if (s1_adv)
        begin
            e_id_reg    <= s1_cmd_reg.id;
            e_area_reg  <= s1_cmd_reg.area;
            e_press_reg <= s1_cmd_reg.pressure;
            e_vx_reg    <= s1_cmd_reg.raw_x;
            e_vy_reg    <= s1_cmd_reg.raw_y;
            e_qx_reg    <= div_mag(s1_px_reg);
            e_qy_reg    <= div_mag(s1_py_reg);
            e_nx_reg    <= s1_px_reg[28];
            e_ny_reg    <= s1_py_reg[28];
        end
        if (emit)
        begin
            kind_reg <= kind_sel;
            last_reg <= last_sel;
            unique case (kind_sel)
                KIND_DOWN:
                begin
                    id_reg    <= e_id_reg;
                    pos_x_reg <= finish_axis(e_vx_reg, e_qx_reg, e_nx_reg, cfg.x_shift,
                                             cfg.x_lower, cfg.x_upper);
                    pos_y_reg <= finish_axis(e_vy_reg, e_qy_reg, e_ny_reg, cfg.y_shift,
                                             cfg.y_lower, cfg.y_upper);
                    major_reg <= e_press_reg;
                    width_reg <= e_area_reg;
                end
                KIND_RELEASE:
                begin
                    id_reg    <= rel_id;
                    pos_x_reg <= '0;
                    pos_y_reg <= '0;
                    major_reg <= '0;
                    width_reg <= '0;
                end
                default:
                begin
                    id_reg    <= '0;
                    pos_x_reg <= '0;
                    pos_y_reg <= '0;
                    major_reg <= '0;
                    width_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign report_kind = kind_reg;
    assign slot_id     = id_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign touch_major = major_reg;
    assign width_major = width_reg;
    assign last_of_run = last_reg;

endmodule

FILE: rtl/core/touch_slot_decoder_with_calibration_core.sv
// Top level of the touch slot decoder: configuration registers, front end,
// command queue and back end. Uses tsdc_pkg, tsdc_front, tsdc_queue, tsdc_back.
//
// Input channel: one six-byte slot record per word (in_valid / in_stall),
// SLOTS_PER_FRAME records to a frame. Output channel: one report per word
// (out_valid / out_stall), with last_of_run set on the final report of a record.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; ready is
// always high, writes are registered, and the user must write only while the
// block is idle, which the block does not enforce. Throughput: one record per
// cycle while the queue has room; the back end's report sequencer delivers one
// report per cycle while the output is not stalled, and a record causes zero or
// one report mid-frame, up to nine (down report, releases of ids 1 to 7, sync)
// on the last slot of a frame. From the queue a record passes the gain multiply,
// the divide-by-1000 multiply and the clamp into the output register. Records
// that cause no report are dropped at the front. A stalled output holds its
// report; the sequencer and the pipeline behind it hold, the queue fills, and
// in_stall rises once QUEUE_DEPTH commands wait. Reset clears the masks, frame
// position, queue and valid flags and loads the configuration reset values;
// the first record after reset opens a frame.
module touch_slot_decoder_with_calibration_core
    import tsdc_pkg::*;
#(
    parameter int SLOTS_PER_FRAME = SLOTS_PER_FRAME_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             id_status,
    input  logic [7:0]             x_high,
    input  logic [7:0]             y_high,
    input  logic [7:0]             xy_low,
    input  logic [7:0]             contact_area,
    input  logic [7:0]             contact_pressure,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             report_kind,
    output logic [4:0]             slot_id,
    output logic [11:0]            pos_x,
    output logic [11:0]            pos_y,
    output logic [7:0]             touch_major,
    output logic [7:0]             width_major,
    output logic                   last_of_run,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;
    logic queue_full;
    logic queue_not_empty;
    logic queue_push;
    logic queue_pop;
    cmd_t front_cmd;
    cmd_t head_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_lower <= 12'd0;
            cfg_reg.x_upper <= 12'd4095;
            cfg_reg.y_lower <= 12'd0;
            cfg_reg.y_upper <= 12'd4095;
            cfg_reg.x_gain  <= '0;
            cfg_reg.y_gain  <= '0;
            cfg_reg.x_shift <= '0;
            cfg_reg.y_shift <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_X_LOWER: cfg_reg.x_lower <= cfg_data[11:0];
                CFG_X_UPPER: cfg_reg.x_upper <= cfg_data[11:0];
                CFG_Y_LOWER: cfg_reg.y_lower <= cfg_data[11:0];
                CFG_Y_UPPER: cfg_reg.y_upper <= cfg_data[11:0];
                CFG_X_GAIN:  cfg_reg.x_gain  <= $signed(cfg_data[15:0]);
                CFG_Y_GAIN:  cfg_reg.y_gain  <= $signed(cfg_data[15:0]);
                CFG_X_SHIFT: cfg_reg.x_shift <= $signed(cfg_data[12:0]);
                CFG_Y_SHIFT: cfg_reg.y_shift <= $signed(cfg_data[12:0]);
            endcase
        end
    end

    tsdc_front #(
        .SLOTS_PER_FRAME (SLOTS_PER_FRAME)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .id_status        (id_status),
        .x_high           (x_high),
        .y_high           (y_high),
        .xy_low           (xy_low),
        .contact_area     (contact_area),
        .contact_pressure (contact_pressure),
        .queue_full       (queue_full),
        .push             (queue_push),
        .cmd              (front_cmd)
    );

    tsdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .wdata     (front_cmd),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .rdata     (head_cmd)
    );

    tsdc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (queue_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (queue_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .report_kind (report_kind),
        .slot_id     (slot_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .touch_major (touch_major),
        .width_major (width_major),
        .last_of_run (last_of_run)
    );

endmodule

FILE: rtl/core/tsdc_checker.sv
// Port-level checker of the touch slot decoder, bound to the top level.
// Uses tsdc_pkg and the assertion macros header.
`include "touch_slot_decoder_with_calibration_core_assert.svh"

module tsdc_checker
    import tsdc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  report_kind,
    input logic [4:0]  slot_id,
    input logic [11:0] pos_x,
    input logic [11:0] pos_y,
    input logic [7:0]  touch_major,
    input logic [7:0]  width_major,
    input logic        last_of_run
);

    logic [47:0] out_word;
    logic        sync_ok;
    logic        rel_ok;
    logic        kind_ok;

    assign out_word = {report_kind, slot_id, pos_x, pos_y, touch_major, width_major,
                       last_of_run};
    assign sync_ok  = last_of_run && (slot_id == 5'd0) && (pos_x == 12'd0)
                      && (pos_y == 12'd0);
    assign rel_ok   = !last_of_run && (slot_id != 5'd0) && (slot_id[4:3] == 2'b00)
                      && (touch_major == 8'd0);
    assign kind_ok  = (report_kind == KIND_DOWN) || (report_kind == KIND_RELEASE)
                      || (report_kind == KIND_SYNC);

    // Hold a stalled report.
    `TSDC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

    // A sync always closes the run of its record.
    `TSDC_ASSERT_IMP(a_sync_last, clk, rst_n, out_valid && (report_kind == KIND_SYNC), sync_ok)

    // Releases only for tracked ids 1 to 7, never the last report of their run.
    `TSDC_ASSERT_IMP(a_release_id, clk, rst_n, out_valid && (report_kind == KIND_RELEASE), rel_ok)

    // Only the three report kinds appear.
    `TSDC_ASSERT_IMP(a_kind_legal, clk, rst_n, out_valid, kind_ok)

endmodule

bind touch_slot_decoder_with_calibration_core tsdc_checker u_tsdc_checker (.*);
